// ===== hdl/cef_pkg.sv =====
`timescale 1ns / 1ps
package cef_pkg;

    typedef logic [1:0] op_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_PUSH  = 2'd0;
    localparam op_t OP_POST  = 2'd1;
    localparam op_t OP_POP   = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

    localparam status_t ST_APPENDED  = 3'd0;
    localparam status_t ST_COALESCED = 3'd1;
    localparam status_t ST_DROPPED   = 3'd2;
    localparam status_t ST_POPPED    = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [7:0]  kind;
        logic [1:0]  bank;
        logic [4:0]  knob;
        logic [31:0] value;
        logic        fin;
    } entry_t;

endpackage

// ===== hdl/coalescing_event_fifo.sv =====
`timescale 1ns / 1ps
// Coalescing event queue: a ring of DEPTH entries with one slot kept free,
// so at most DEPTH-1 events are queued.
// Command channel: an operation (push, knob post, pop, clear) is taken at a
// rising edge where start is high and busy is low. Each operation yields one
// result beat: done is high for exactly one cycle with status, the popped
// entry fields (zero unless popped) and fill_count after the operation.
// The receiver cannot stall; a result beat is only shown once.
// Timing: push and clear give their beat on the cycle after acceptance and
// keep busy low, so they can be issued every cycle. A pop goes busy while it
// reads the entry memory synchronously in S_POP, but answers on an empty
// queue like a push. A knob post walks the queue from oldest to newest through
// the single memory read port, one entry a cycle, and stays busy until it
// coalesces into a matching entry or appends or drops the event at the end.
// Configuration: cfg_wr_en writes cfg_wr_data into the knob-change kind code
// (reset value 1); write it only while the queue is idle. A new code also
// applies to entries already queued.
// Reset empties the queue and clears busy and done; entry memory contents
// are not cleared, as only written entries are ever read.
module coalescing_event_fifo
    import cef_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  event_kind,
    input  logic [1:0]  bank,
    input  logic [4:0]  knob_number,
    input  logic [31:0] value_bits,
    input  logic        final_flag,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  out_kind,
    output logic [1:0]  out_bank,
    output logic [4:0]  out_knob,
    output logic [31:0] out_value,
    output logic        out_final,
    output logic [4:0]  fill_count
);

    localparam int PW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] scan_reg, scan_next;
    logic [PW-1:0] cmp_addr_reg, cmp_addr_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [7:0]    knob_kind_reg;

    logic [1:0]    bank_reg;
    logic [4:0]    knob_reg;
    logic [31:0]   value_reg;
    logic          fin_reg;

    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    entry_t        out_entry_reg, out_entry_next;
    logic [4:0]    fill_count_reg;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          rd_en;
    logic [PW-1:0] rd_addr;

    logic          accept;
    logic          full;
    logic          match;
    logic [PW:0]   fill;
    logic [31:0]   fill_ext;

    assign accept = start && (state_reg == S_IDLE);
    assign full   = (advance(wp_reg) == rp_reg);
    assign match  = (rd_data_reg.kind == knob_kind_reg) && (rd_data_reg.bank == bank_reg)
                    && (rd_data_reg.knob == knob_reg);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        scan_next      = scan_reg;
        cmp_addr_next  = cmp_addr_reg;
        cmp_valid_next = 1'b0;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_entry_next = '0;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = '0;
        rd_en          = 1'b0;
        rd_addr        = rp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_DROPPED;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = '{kind: event_kind, bank: bank,
                                                knob: knob_number, value: value_bits,
                                                fin: final_flag};
                                wp_next     = advance(wp_reg);
                                status_next = ST_APPENDED;
                            end
                        end
                        OP_POST:
                        begin
                            scan_next  = rp_reg;
                            state_next = S_SCAN;
                        end
                        OP_POP:
                        begin
                            if (rp_reg == wp_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next     = '0;
                            rp_next     = '0;
                            done_next   = 1'b1;
                            status_next = ST_CLEARED;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                out_entry_next = rd_data_reg;
                rp_next        = advance(rp_reg);
                done_next      = 1'b1;
                status_next    = ST_POPPED;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (cmp_valid_reg && match)
                begin
                    // coalesce in place; final is sticky
                    mem_we          = 1'b1;
                    mem_waddr       = cmp_addr_reg;
                    mem_wdata       = rd_data_reg;
                    mem_wdata.value = value_reg;
                    mem_wdata.fin   = rd_data_reg.fin | fin_reg;
                    done_next       = 1'b1;
                    status_next     = ST_COALESCED;
                    state_next      = S_IDLE;
                end
                else if (scan_reg != wp_reg)
                begin
                    // read the next entry while the previous one is compared
                    rd_en          = 1'b1;
                    rd_addr        = scan_reg;
                    cmp_addr_next  = scan_reg;
                    cmp_valid_next = 1'b1;
                    scan_next      = advance(scan_reg);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (full)
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = '{kind: knob_kind_reg, bank: bank_reg, knob: knob_reg,
                                        value: value_reg, fin: fin_reg};
                        wp_next     = advance(wp_reg);
                        status_next = ST_APPENDED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (wp_next >= rp_next)
            fill = {1'b0, wp_next} - {1'b0, rp_next};
        else
            fill = {1'b0, wp_next} + (PW + 1)'(DEPTH) - {1'b0, rp_next};
    end

    assign fill_ext = 32'(fill);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            knob_kind_reg <= 8'd1;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            if (cfg_wr_en)
                knob_kind_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        cmp_addr_reg <= cmp_addr_next;
        if (accept)
        begin
            bank_reg  <= bank;
            knob_reg  <= knob_number;
            value_reg <= value_bits;
            fin_reg   <= final_flag;
        end
        if (done_next)
        begin
            status_reg     <= status_next;
            out_entry_reg  <= out_entry_next;
            fill_count_reg <= fill_ext[4:0];
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_kind   = out_entry_reg.kind;
    assign out_bank   = out_entry_reg.bank;
    assign out_knob   = out_entry_reg.knob;
    assign out_value  = out_entry_reg.value;
    assign out_final  = out_entry_reg.fin;
    assign fill_count = fill_count_reg;

endmodule

// ===== hdl/cef_checker.sv =====
`timescale 1ns / 1ps
module cef_checker
    import cef_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        done,
    input logic [2:0]  status,
    input logic [7:0]  out_kind,
    input logic [31:0] out_value,
    input logic        out_final,
    input logic [4:0]  fill_count
);

    // a clear empties the queue on the next beat
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_CLEAR |=> done && status == ST_CLEARED && fill_count == 5'd0)
        else $error("clear did not answer with an empty queue");

    // a push answers on the next cycle without going busy
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_PUSH |=> done && !busy
            && (status == ST_APPENDED || status == ST_DROPPED))
        else $error("push beat missing or malformed");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_POPPED |-> out_kind == 8'd0 && out_value == 32'd0 && !out_final)
        else $error("entry fields not zero outside a pop");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> fill_count == 5'd0)
        else $error("empty pop with entries queued");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_CLEARED)
        else $error("status code out of range");

endmodule

bind coalescing_event_fifo cef_checker u_cef_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .done       (done),
    .status     (status),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_final  (out_final),
    .fill_count (fill_count)
);
